// ===== src/sdf_pkg.sv =====
// ----------------------------------------------------------------------------
// sdf_pkg
// Shared types and constants of the signed decimal field formatter.
// ----------------------------------------------------------------------------
package sdf_pkg;

	// Field size limit: the smaller of MAX_FIELD and the result capacity
	localparam int MAX_FIELD   = 64;
	localparam int OUT_CAP     = 64;
	localparam int FIELD_LIMIT = (MAX_FIELD < OUT_CAP) ? MAX_FIELD : OUT_CAP;
	localparam int FLD_W       = $clog2(FIELD_LIMIT + 1);

	// Decimal conversion
	localparam int NDIG_MAX  = 10;
	localparam int DIG_IDX_W = $clog2(NDIG_MAX);
	localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;   // ceil(2^35 / 10)

	// Stream widths
	localparam int IN_TDATA_W  = 56;
	localparam int OUT_TDATA_W = 40;

	// Characters
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_MINUS = 8'h2D;

	// Classified item passed from the front part to the back part
	typedef struct packed {
		logic [31:0]      mag;
		logic             neg;
		logic [FLD_W-1:0] width;
		logic [FLD_W-1:0] prec;
		logic             has_prec;
		logic             left;
		logic             zpad;
	} item_t;

	// Back part sequencer
	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_CONV = 4'b0010,
		S_PLAN = 4'b0100,
		S_EMIT = 4'b1000
	} back_state_t;

endpackage

// ===== src/sdf_front.sv =====
// ----------------------------------------------------------------------------
// sdf_front
// Accepts input items and classifies them: magnitude and sign, effective
// width and justification, saturated precision and effective zero padding.
// ----------------------------------------------------------------------------
module sdf_front import sdf_pkg::*; (
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_TDATA_W-1:0] s_axis_tdata,
	input  logic                  q_full,
	output logic                  push,
	output item_t                 item
);

	logic [31:0] value;
	logic [7:0]  fw;
	logic [6:0]  pbits;
	logic        left_align;
	logic        zero_pad;
	logic [7:0]  wabs;
	logic [7:0]  plim;
	logic [7:0]  praw;
	logic        left_eff;
	logic        has_prec;

	// Unpack
	assign value      = s_axis_tdata[31:0];
	assign fw         = s_axis_tdata[39:32];
	assign pbits      = s_axis_tdata[46:40];
	assign left_align = s_axis_tdata[47];
	assign zero_pad   = s_axis_tdata[48];

	// Handshake
	assign s_axis_tready = !q_full;
	assign push          = s_axis_tvalid && !q_full;

	// Classification
	always_comb begin
		left_eff = left_align || fw[7];
		wabs     = fw[7] ? (8'd0 - fw) : fw;
		has_prec = !pbits[6];
		praw     = has_prec ? {2'b00, pbits[5:0]} : 8'd0;
		plim     = 8'(FIELD_LIMIT) - {7'd0, value[31]};

		item.neg      = value[31];
		item.mag      = value[31] ? (32'd0 - value) : value;
		item.left     = left_eff;
		item.has_prec = has_prec;
		item.width    = (wabs > 8'(FIELD_LIMIT)) ? FLD_W'(FIELD_LIMIT) : wabs[FLD_W-1:0];
		item.prec     = (praw > plim) ? plim[FLD_W-1:0] : praw[FLD_W-1:0];
		item.zpad     = zero_pad && !has_prec && !left_eff;
	end

endmodule

// ===== src/sdf_queue.sv =====
// ----------------------------------------------------------------------------
// sdf_queue
// Two-entry queue of classified items between front and back parts.
// ----------------------------------------------------------------------------
module sdf_queue import sdf_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	input  logic  pop,
	output logic  full,
	output logic  head_valid,
	output item_t head
);

	item_t       ent_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  cnt_q;

	assign full       = (cnt_q == 2'd2);
	assign head_valid = (cnt_q != 2'd0);
	assign head       = ent_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_ptr_q] <= push_item;
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("queue count out of range");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop)) else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && !head_valid)) else $error("pop from empty queue");

endmodule

// ===== src/sdf_back.sv =====
// ----------------------------------------------------------------------------
// sdf_back
// Takes classified items from the queue, converts the magnitude to decimal
// one digit per cycle, lays out the field and emits it one character per
// cycle while the output is taken, through an output register.
// ----------------------------------------------------------------------------
module sdf_back import sdf_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   head_valid,
	input  item_t                  head,
	output logic                   pop,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	output logic                   m_axis_tlast
);

	back_state_t          state_q;
	item_t                item_q;
	logic [31:0]          cur_q;
	logic [3:0]           dig_q [NDIG_MAX];
	logic [DIG_IDX_W-1:0] step_q;
	logic [3:0]           nz_q;
	logic [FLD_W-1:0]     b0_q, b1_q, b2_q, b3_q, len_q, idx_q;
	logic [31:0]          tot_q;
	logic                 out_vld_q;
	logic                 out_last_q;
	logic [7:0]           out_char_q;
	logic [31:0]          out_tot_q;

	// Divide by ten via reciprocal
	logic [63:0] prod;
	logic [31:0] quo;
	logic [31:0] rem;
	always_comb begin
		prod = {32'd0, cur_q} * {32'd0, RECIP10};
		quo  = {3'd0, prod[63:35]};
		rem  = cur_q - ((quo << 3) + (quo << 1));
	end

	// Field layout
	logic [7:0] ndig, sgn, zeros, body, len, lead, wid, prc;
	always_comb begin
		wid = 8'(item_q.width);
		prc = 8'(item_q.prec);
		sgn = {7'd0, item_q.neg};
		if (item_q.has_prec && prc == 8'd0 && nz_q == 4'd0)
			ndig = 8'd0;
		else if (nz_q == 4'd0)
			ndig = 8'd1;
		else
			ndig = {4'd0, nz_q};
		if (item_q.has_prec && prc > ndig)
			zeros = prc - ndig;
		else if (item_q.zpad && wid > sgn + ndig)
			zeros = wid - sgn - ndig;
		else
			zeros = 8'd0;
		body = sgn + zeros + ndig;
		len  = (wid > body) ? wid : body;
		lead = item_q.left ? 8'd0 : len - body;
	end

	// Character select
	logic                 out_adv;
	logic [FLD_W-1:0]     dpos;
	logic [7:0]           ch;
	logic                 is_last;
	always_comb begin
		out_adv = !out_vld_q || m_axis_tready;
		dpos    = b3_q - FLD_W'(1) - idx_q;
		is_last = (idx_q == len_q - FLD_W'(1));
		if (idx_q < b0_q || idx_q >= b3_q)
			ch = CH_SPACE;
		else if (idx_q < b1_q)
			ch = CH_MINUS;
		else if (idx_q < b2_q)
			ch = CH_ZERO;
		else
			ch = CH_ZERO | {4'd0, dig_q[dpos[DIG_IDX_W-1:0]]};
	end

	assign pop = (state_q == S_IDLE) && head_valid;

	// Sequencer and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			step_q    <= '0;
			nz_q      <= '0;
			idx_q     <= '0;
			tot_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			// output register: load a character or drop once taken
			if (state_q == S_EMIT && out_adv)
				out_vld_q <= 1'b1;
			else if (m_axis_tready)
				out_vld_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (head_valid) begin
						step_q  <= '0;
						nz_q    <= '0;
						state_q <= S_CONV;
					end
				end
				S_CONV: begin
					if (cur_q != 32'd0)
						nz_q <= nz_q + 4'd1;
					step_q <= step_q + DIG_IDX_W'(1);
					if (step_q == DIG_IDX_W'(NDIG_MAX - 1))
						state_q <= S_PLAN;
				end
				S_PLAN: begin
					idx_q   <= '0;
					state_q <= (len == 8'd0) ? S_IDLE : S_EMIT;
				end
				S_EMIT: begin
					if (out_adv) begin
						tot_q     <= tot_q + 32'd1;
						idx_q     <= idx_q + FLD_W'(1);
						if (is_last)
							state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				item_q <= head;
				cur_q  <= head.mag;
			end
			S_CONV: begin
				cur_q <= quo;
				for (int i = 0; i < NDIG_MAX - 1; i++)
					dig_q[i] <= dig_q[i+1];
				dig_q[NDIG_MAX-1] <= rem[3:0];
			end
			S_PLAN: begin
				len_q <= len[FLD_W-1:0];
				b0_q  <= lead[FLD_W-1:0];
				b1_q  <= FLD_W'(lead + sgn);
				b2_q  <= FLD_W'(lead + sgn + zeros);
				b3_q  <= FLD_W'(lead + body);
			end
			S_EMIT: begin
				if (out_adv) begin
					out_char_q <= ch;
					out_last_q <= is_last;
					out_tot_q  <= tot_q + 32'd1;
				end
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {out_tot_q, out_char_q};
	assign m_axis_tlast  = out_last_q;

	a_conv_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CONV && step_q == DIG_IDX_W'(NDIG_MAX - 1)) |=> state_q == S_PLAN)
		else $error("conversion did not end after ten digits");
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT |-> idx_q < len_q)
		else $error("character index beyond field length");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && out_adv) |=> tot_q == $past(tot_q) + 32'd1)
		else $error("character count did not advance by one");
	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_EMIT |=> $stable(tot_q))
		else $error("character count changed outside emission");

endmodule

// ===== src/signed_decimal_field_formatter.sv =====
// Formats one signed 32-bit integer per item as a printf "%d" style ASCII field
// and emits it one character per output item, with tlast on the final one and
// the running character count beside each character. The back part takes an
// item from the queue, converts all ten decimal digits through a single
// reciprocal multiplier, lays out the field (0 to 64 characters long), then
// emits one character per cycle while the output is taken. A field of length
// zero emits nothing. The front part keeps accepting items while the
// two-entry queue has room.
// ----------------------------------------------------------------------------
// signed_decimal_field_formatter
// Top level: front classifier, item queue and back formatter.
// ----------------------------------------------------------------------------
module signed_decimal_field_formatter import sdf_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// [31:0] value, [39:32] field_width, [46:40] precision, [47] left_align,
	// [48] zero_pad, [55:49] zero
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// [7:0] out_char, [39:8] total_written
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	output logic                   m_axis_tlast
);

	logic  push;
	logic  pop;
	logic  q_full;
	logic  head_valid;
	item_t push_item;
	item_t head;

	sdf_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.q_full        (q_full),
		.push          (push),
		.item          (push_item)
	);

	sdf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head)
	);

	sdf_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head          (head),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule
